/* rtl/dwsp_pkg.sv */
package dwsp_pkg;

    // Field widths of the stream items
    localparam int PULSE_W  = 15;
    localparam int TARGET_W = 23;
    localparam int GAIN_W   = 16;
    localparam int DUTY_W   = 13;
    localparam int DIST_W   = 32;

    // Speed = signed count * 119 in Q.6; |speed| <= 32767*119 fits 23 bits signed
    localparam int SPEED_W  = 23;
    localparam int ERR_W    = 24;
    localparam logic signed [8:0] SPEED_MUL = 9'sd119;

    // Controller output clamp, whole units
    localparam int OUT_LIMIT = 7500;

    // Wide enough for integral + P + D before the output clamp
    localparam int SUM_W = 36;

    // Defaults for the top-level parameters
    localparam int unsigned DUTY_LIMIT_DEF     = 6500;
    localparam int unsigned INTEGRAL_LIMIT_DEF = 3000;

    // Configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam logic [CFG_ADDR_W-1:0] REG_KP_LEFT  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_KI_LEFT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_KD_LEFT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_KP_RIGHT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_KI_RIGHT = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_KD_RIGHT = 3'd5;

    // PID gains of one wheel, unsigned Q8.8
    typedef struct packed {
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
    } gain_t;

    // Input item as packed on s_tdata (last member is bit 0)
    typedef struct packed {
        logic                       pad;
        logic signed [TARGET_W-1:0] target_right;
        logic signed [TARGET_W-1:0] target_left;
        logic                       dir_pin_right;
        logic [PULSE_W-1:0]         pulses_right;
        logic                       dir_pin_left;
        logic [PULSE_W-1:0]         pulses_left;
        logic                       enable;
    } in_item_t;

    // Result item as packed on m_tdata (last member is bit 0)
    typedef struct packed {
        logic [3:0]        pad;
        logic [DIST_W-1:0] travel_right;
        logic [DIST_W-1:0] travel_left;
        logic              motor_dir_right;
        logic [DUTY_W-1:0] duty_right;
        logic              motor_dir_left;
        logic [DUTY_W-1:0] duty_left;
    } out_item_t;

endpackage

/* rtl/dwsp_wheel.sv */
module dwsp_wheel #(
    parameter int unsigned DUTY_LIMIT     = dwsp_pkg::DUTY_LIMIT_DEF,
    parameter int unsigned INTEGRAL_LIMIT = dwsp_pkg::INTEGRAL_LIMIT_DEF,
    parameter logic        DIR_INIT       = 1'b0
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 step,
    input  logic                                 enable,
    input  logic                                 neg,
    input  logic [dwsp_pkg::PULSE_W-1:0]         pulses,
    input  logic signed [dwsp_pkg::TARGET_W-1:0] target,
    input  dwsp_pkg::gain_t                      gains,
    output logic [dwsp_pkg::DUTY_W-1:0]          duty,
    output logic                                 motor_dir,
    output logic [dwsp_pkg::DIST_W-1:0]          travel
);
    import dwsp_pkg::*;

    localparam int ILIM  = INTEGRAL_LIMIT * 64;
    localparam int IW    = $clog2(ILIM + 1) + 1;
    localparam int OLIM  = OUT_LIMIT * 64;
    localparam int OW    = $clog2(OLIM + 1) + 1;
    localparam int MW    = OW - 6;
    localparam int CMPW  = 17;
    localparam int DIFF_W = ERR_W + 1;
    localparam int PW    = GAIN_W + 1 + ERR_W;
    localparam int DW    = GAIN_W + 1 + DIFF_W;

    localparam logic signed [SUM_W-1:0] ILIM_S = SUM_W'(ILIM);
    localparam logic signed [SUM_W-1:0] OLIM_S = SUM_W'(OLIM);
    localparam logic [CMPW-1:0]         DLIM   = CMPW'(DUTY_LIMIT);

    logic signed [IW-1:0]     integ_reg, integ_next;
    logic signed [ERR_W-1:0]  prev_reg;
    logic [DIST_W-1:0]        dist_reg, dist_next;
    logic                     dir_reg;

    logic signed [PULSE_W:0]    cnt;
    logic signed [SPEED_W-1:0]  speed, speed_adj, speed_int;
    logic signed [ERR_W-1:0]    err;
    logic signed [DIFF_W-1:0]   diff;
    logic signed [PW-1:0]       p_prod, i_prod;
    logic signed [DW-1:0]       d_prod;
    logic signed [PW-9:0]       p_term, i_term;
    logic signed [DW-9:0]       d_term;
    logic signed [SUM_W-1:0]    integ_sum, out_sum;
    logic signed [OW-1:0]       out_c;
    logic [OW-1:0]              mag;
    logic [MW-1:0]              mag_int;
    logic [DUTY_W-1:0]          duty_c;
    logic                       dir_c;

    // Signed encoder speed in Q.6 and its whole part (toward zero)
    always_comb begin
        cnt       = neg ? -$signed({1'b0, pulses}) : $signed({1'b0, pulses});
        speed     = SPEED_W'(cnt * SPEED_MUL);
        speed_adj = speed + $signed({{(SPEED_W-6){1'b0}}, {6{speed[SPEED_W-1]}}});
        speed_int = speed_adj >>> 6;
        dist_next = dist_reg + {{(DIST_W-SPEED_W){speed_int[SPEED_W-1]}}, speed_int};
    end

    // Error terms and gain products; dropping 8 low bits is a floor shift
    always_comb begin
        err    = ERR_W'(target) - ERR_W'(speed);
        diff   = DIFF_W'(err) - DIFF_W'(prev_reg);
        p_prod = $signed({1'b0, gains.kp}) * err;
        i_prod = $signed({1'b0, gains.ki}) * err;
        d_prod = $signed({1'b0, gains.kd}) * diff;
        p_term = p_prod[PW-1:8];
        i_term = i_prod[PW-1:8];
        d_term = d_prod[DW-1:8];
    end

    // Sum, clamps and duty
    always_comb begin
        integ_sum = SUM_W'(integ_reg) + SUM_W'(i_term);
        out_sum   = integ_sum + SUM_W'(p_term) + SUM_W'(d_term);

        if (out_sum > OLIM_S) begin
            out_c = OW'(OLIM_S);
        end else if (out_sum < -OLIM_S) begin
            out_c = OW'(-OLIM_S);
        end else begin
            out_c = OW'(out_sum);
        end

        if (integ_sum > ILIM_S) begin
            integ_next = IW'(ILIM_S);
        end else if (integ_sum < -ILIM_S) begin
            integ_next = IW'(-ILIM_S);
        end else begin
            integ_next = IW'(integ_sum);
        end

        dir_c   = out_c[OW-1];
        mag     = dir_c ? OW'(-out_c) : OW'(out_c);
        mag_int = mag[OW-1:6];
        if (CMPW'(mag_int) > DLIM) begin
            duty_c = DUTY_W'(DLIM);
        end else begin
            duty_c = DUTY_W'(mag_int);
        end
    end

    assign duty      = enable ? duty_c : '0;
    assign motor_dir = enable ? dir_c : dir_reg;
    assign travel    = dist_next;

    // Wheel state: distance every transaction, PID state only when enabled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            integ_reg <= '0;
            prev_reg  <= '0;
            dist_reg  <= '0;
            dir_reg   <= DIR_INIT;
        end else if (step) begin
            dist_reg <= dist_next;
            if (enable) begin
                integ_reg <= integ_next;
                prev_reg  <= err;
                dir_reg   <= dir_c;
            end
        end
    end

    a_integ_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (SUM_W'(integ_reg) <= ILIM_S) && (SUM_W'(integ_reg) >= -ILIM_S))
        else $error("integral outside its clamp");

    a_idle_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step |=> $stable(integ_reg) && $stable(prev_reg) && $stable(dist_reg))
        else $error("wheel state moved without a transaction");

    a_disabled_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !enable) |=> $stable(integ_reg) && $stable(prev_reg) && $stable(dir_reg))
        else $error("PID state changed on a disabled tick");

endmodule

/* rtl/dual_wheel_speed_pid.sv */
// Dual wheel speed loop.
// One input transaction on s_* carries a control tick: enable, both encoder
// counts with direction pins and both target speeds. Each tick yields exactly
// one result transaction on m_*: duty magnitude and drive direction per wheel,
// plus the accumulated travel of each wheel.
// Gains are written through cfg_wr_en/cfg_addr/cfg_wdata, one 16-bit register
// per write, addresses 0..5 (kp, ki, kd left, then right); other addresses are
// ignored. Write gains only while no tick is in flight.
// A tick passes the input register, then the result register, before it is
// presented on m_tdata. Throughput is one tick per cycle while m_tready is high;
// the PID update is one combinational pass between the two registers, with
// three gain multipliers per wheel.
// Reset (aresetn low, synchronous) clears gains, integrals, previous errors,
// distances and the valid flags; held directions return to left 1, right 0.
// When m_tready is low a full result register holds, the input register still
// takes one more tick, and s_tready drops only when both are full.
module dual_wheel_speed_pid #(
    parameter int unsigned DUTY_LIMIT     = dwsp_pkg::DUTY_LIMIT_DEF,
    parameter int unsigned INTEGRAL_LIMIT = dwsp_pkg::INTEGRAL_LIMIT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // enable, pulses_left, dir_pin_left, pulses_right, dir_pin_right,
    // target_left, target_right (bit 0 up), one zero pad bit on top
    input  logic [79:0]                       s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // duty_left, motor_dir_left, duty_right, motor_dir_right, travel_left,
    // travel_right (bit 0 up), four zero pad bits on top
    output logic [95:0]                       m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic [dwsp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [dwsp_pkg::GAIN_W-1:0]       cfg_wdata
);
    import dwsp_pkg::*;

    gain_t     gains_l_reg, gains_r_reg;
    in_item_t  in_data_reg;
    out_item_t out_data_reg, out_data_next;
    logic      in_vld_reg, in_vld_next;
    logic      out_vld_reg, out_vld_next;
    logic      adv, step, s_fire;

    // Gain registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gains_l_reg <= '0;
            gains_r_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_KP_LEFT:  gains_l_reg.kp <= cfg_wdata;
                REG_KI_LEFT:  gains_l_reg.ki <= cfg_wdata;
                REG_KD_LEFT:  gains_l_reg.kd <= cfg_wdata;
                REG_KP_RIGHT: gains_r_reg.kp <= cfg_wdata;
                REG_KI_RIGHT: gains_r_reg.ki <= cfg_wdata;
                REG_KD_RIGHT: gains_r_reg.kd <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake: input register feeds result register
    assign adv      = !out_vld_reg || m_tready;
    assign step     = in_vld_reg && adv;
    assign s_tready = !in_vld_reg || adv;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_vld_next = s_fire ? 1'b1 : (step ? 1'b0 : in_vld_reg);
        out_vld_next = step ? 1'b1 : (m_tready ? 1'b0 : out_vld_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg <= in_item_t'(s_tdata);
        end
        if (step) begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_data_next.pad = '0;

    dwsp_wheel #(
        .DUTY_LIMIT     (DUTY_LIMIT),
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
        .DIR_INIT       (1'b1)
    ) u_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .enable    (in_data_reg.enable),
        .neg       (!in_data_reg.dir_pin_left),
        .pulses    (in_data_reg.pulses_left),
        .target    (in_data_reg.target_left),
        .gains     (gains_l_reg),
        .duty      (out_data_next.duty_left),
        .motor_dir (out_data_next.motor_dir_left),
        .travel    (out_data_next.travel_left)
    );

    dwsp_wheel #(
        .DUTY_LIMIT     (DUTY_LIMIT),
        .INTEGRAL_LIMIT (INTEGRAL_LIMIT),
        .DIR_INIT       (1'b0)
    ) u_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .enable    (in_data_reg.enable),
        .neg       (in_data_reg.dir_pin_right),
        .pulses    (in_data_reg.pulses_right),
        .target    (in_data_reg.target_right),
        .gains     (gains_r_reg),
        .duty      (out_data_next.duty_right),
        .motor_dir (out_data_next.motor_dir_right),
        .travel    (out_data_next.travel_right)
    );

    assign m_tdata  = 96'(out_data_reg);
    assign m_tvalid = out_vld_reg;

    a_ready_low: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_vld_reg && out_vld_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

    a_disabled_duty: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !in_data_reg.enable) |=>
        (out_data_reg.duty_left == '0) && (out_data_reg.duty_right == '0))
        else $error("nonzero duty on a disabled tick");

    a_duty_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (32'(out_data_reg.duty_left) <= DUTY_LIMIT) &&
                     (32'(out_data_reg.duty_right) <= DUTY_LIMIT))
        else $error("duty above limit");

    a_stall_keeps_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_vld_reg && out_vld_reg && !m_tready) |=> in_vld_reg)
        else $error("pending tick dropped during output stall");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import dwsp_pkg::*;

    localparam int     CYCLE_LIMIT = 250000;
    localparam int     PHASE_TICKS = 300;
    localparam longint SPEED_GAIN  = 119;
    localparam longint OUT_CLAMP   = 64 * OUT_LIMIT;
    localparam longint INTEG_CLAMP = 64 * longint'(INTEGRAL_LIMIT_DEF);
    localparam longint DUTY_CAP    = longint'(DUTY_LIMIT_DEF);

    // Addresses past the gain bank; writes there must change nothing
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_LO = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED_HI = 3'd7;

    // Speed loop predictor and result queue for both wheels
    class wheel_pid_scoreboard;
        longint            gain [6];
        longint            integ [2];
        longint            prev_err [2];
        logic [DIST_W-1:0] travel_acc [2];
        logic              held_dir [2];
        out_item_t         expected [$];
        int                errors = 0;
        int                ticks = 0;
        int                idle_ticks = 0;
        int                checked = 0;
        int                saturated = 0;
        int                reversed = 0;

        function new();
            foreach (gain[i]) gain[i] = 0;
            integ      = '{0, 0};
            prev_err   = '{0, 0};
            travel_acc = '{'0, '0};
            held_dir   = '{1'b1, 1'b0};
        endfunction

        function void set_gain(logic [CFG_ADDR_W-1:0] idx, logic [GAIN_W-1:0] val);
            if (idx <= REG_KD_RIGHT) gain[idx] = val;
        endfunction

        // Positional PID of one wheel; returns the duty magnitude
        function longint pid_update(int w, longint err, longint kp, longint ki, longint kd);
            longint sum;
            longint mag;
            integ[w] += (ki * err) >>> 8;
            sum = integ[w] + ((kp * err) >>> 8) + ((kd * (err - prev_err[w])) >>> 8);
            if (sum > OUT_CLAMP) sum = OUT_CLAMP;
            else if (sum < -OUT_CLAMP) sum = -OUT_CLAMP;
            prev_err[w] = err;
            // integral is clamped only after it has been used
            if (integ[w] > INTEG_CLAMP) integ[w] = INTEG_CLAMP;
            else if (integ[w] < -INTEG_CLAMP) integ[w] = -INTEG_CLAMP;
            held_dir[w] = (sum < 0);
            mag = (sum < 0) ? -sum : sum;
            mag = mag / 64;
            if (mag > DUTY_CAP) mag = DUTY_CAP;
            if (mag == DUTY_CAP) saturated++;
            if (sum < 0) reversed++;
            return mag;
        endfunction

        // One accepted tick: update the model state and queue its result
        function void note_tick(in_item_t t);
            out_item_t want;
            longint    speed [2];
            longint    duty [2];
            speed[0] = longint'(t.pulses_left) * SPEED_GAIN;
            speed[1] = longint'(t.pulses_right) * SPEED_GAIN;
            if (!t.dir_pin_left) speed[0] = -speed[0];
            if (t.dir_pin_right) speed[1] = -speed[1];
            duty = '{0, 0};
            // travel moves on every tick, truncated toward zero
            for (int w = 0; w < 2; w++) travel_acc[w] += 32'(speed[w] / 64);
            ticks++;
            if (t.enable) begin
                duty[0] = pid_update(0, longint'($signed(t.target_left)) - speed[0],
                                     gain[REG_KP_LEFT], gain[REG_KI_LEFT], gain[REG_KD_LEFT]);
                duty[1] = pid_update(1, longint'($signed(t.target_right)) - speed[1],
                                     gain[REG_KP_RIGHT], gain[REG_KI_RIGHT],
                                     gain[REG_KD_RIGHT]);
            end else begin
                idle_ticks++;
            end
            want = '0;
            want.duty_left       = duty[0][DUTY_W-1:0];
            want.motor_dir_left  = held_dir[0];
            want.duty_right      = duty[1][DUTY_W-1:0];
            want.motor_dir_right = held_dir[1];
            want.travel_left     = travel_acc[0];
            want.travel_right    = travel_acc[1];
            expected.push_back(want);
        endfunction

        function void check_field(string name, logic [DIST_W-1:0] want,
                                  logic [DIST_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (expected.size() == 0) begin
                $error("result transaction with no tick outstanding: %h", got);
                errors++;
                return;
            end
            want = expected.pop_front();
            checked++;
            check_field("duty_left", DIST_W'(want.duty_left), DIST_W'(got.duty_left));
            check_field("motor_dir_left", DIST_W'(want.motor_dir_left),
                        DIST_W'(got.motor_dir_left));
            check_field("duty_right", DIST_W'(want.duty_right), DIST_W'(got.duty_right));
            check_field("motor_dir_right", DIST_W'(want.motor_dir_right),
                        DIST_W'(got.motor_dir_right));
            check_field("travel_left", want.travel_left, got.travel_left);
            check_field("travel_right", want.travel_right, got.travel_right);
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic [79:0]           s_tdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [95:0]           m_tdata;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [GAIN_W-1:0]     cfg_wdata = '0;

    wheel_pid_scoreboard sb;
    bit quiet = 1'b0;
    int stall_left = 0;
    int cycle_count = 0;
    int settings = 0;
    int aim [2];

    dual_wheel_speed_pid u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Result side: check each transaction, stall in random bursts
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 8);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic in_item_t make_tick(logic en, logic [PULSE_W-1:0] pl, logic dpl,
                                           logic [PULSE_W-1:0] pr, logic dpr,
                                           logic [TARGET_W-1:0] tl,
                                           logic [TARGET_W-1:0] tr);
        in_item_t t;
        t.pad           = 1'b0;
        t.enable        = en;
        t.pulses_left   = pl;
        t.dir_pin_left  = dpl;
        t.pulses_right  = pr;
        t.dir_pin_right = dpr;
        t.target_left   = tl;
        t.target_right  = tr;
        return t;
    endfunction

    // Mostly a wheel tracking a slowly changing set point, some raw noise
    function automatic in_item_t rand_tick();
        in_item_t t;
        int pl;
        int pr;
        if ($urandom_range(0, 4) == 0) begin
            t = in_item_t'(80'({$urandom, $urandom, $urandom}));
            t.pad = 1'b0;
            return t;
        end
        if ($urandom_range(0, 19) == 0) aim[0] = int'($urandom_range(0, 60000)) - 30000;
        if ($urandom_range(0, 19) == 0) aim[1] = int'($urandom_range(0, 60000)) - 30000;
        pl = (aim[0] < 0 ? -aim[0] : aim[0]) / 119 + int'($urandom_range(0, 16)) - 8;
        pr = (aim[1] < 0 ? -aim[1] : aim[1]) / 119 + int'($urandom_range(0, 16)) - 8;
        if (pl < 0) pl = 0;
        if (pr < 0) pr = 0;
        return make_tick($urandom_range(0, 15) != 0, PULSE_W'(pl), aim[0] >= 0,
                         PULSE_W'(pr), aim[1] < 0, TARGET_W'(aim[0]), TARGET_W'(aim[1]));
    endfunction

    task automatic send_tick(input in_item_t t);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tdata  <= t;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_tick(t);
    endtask

    // Stop sending and wait until every queued result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [GAIN_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.set_gain(idx, val);
    endtask

    task automatic load_gains(input logic [GAIN_W-1:0] kpl, kil, kdl, kpr, kir, kdr,
                              input logic [CFG_ADDR_W-1:0] spare);
        settle();
        write_reg(REG_KP_LEFT, kpl);
        write_reg(REG_KI_LEFT, kil);
        write_reg(REG_KD_LEFT, kdl);
        write_reg(REG_KP_RIGHT, kpr);
        write_reg(REG_KI_RIGHT, kir);
        write_reg(REG_KD_RIGHT, kdr);
        write_reg(spare, GAIN_W'($urandom));
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    task automatic run_phase(input int n);
        repeat (n) send_tick(rand_tick());
    endtask

    initial begin
        sb  = new();
        aim = '{6000, -6000};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Gains still zero: disabled tick holds directions, enabled gives zero output
        send_tick(make_tick(1'b0, 15'd0, 1'b1, 15'd0, 1'b0, 23'd0, 23'd0));
        send_tick(make_tick(1'b1, 15'd100, 1'b1, 15'd100, 1'b0, 23'd0, 23'd0));

        // Unity proportional gain
        load_gains(16'd256, 16'd0, 16'd0, 16'd256, 16'd0, 16'd0, REG_UNMAPPED_LO);
        send_tick(make_tick(1'b1, 15'd0, 1'b1, 15'd0, 1'b0, -23'sd1, -23'sd63));
        send_tick(make_tick(1'b0, 15'd500, 1'b0, 15'd500, 1'b1, 23'd0, 23'd0));
        send_tick(make_tick(1'b1, 15'd0, 1'b1, 15'd0, 1'b0, 23'h3FFFFF, 23'h3FFFFF));
        send_tick(make_tick(1'b1, 15'h7FFF, 1'b1, 15'h7FFF, 1'b0, 23'h400000, 23'h400000));
        send_tick(make_tick(1'b1, 15'h7FFF, 1'b0, 15'h7FFF, 1'b1, 23'h3FFFFF, 23'h3FFFFF));
        send_tick(make_tick(1'b1, 15'd0, 1'b1, 15'd0, 1'b0, 23'd6400, 23'd6400));
        send_tick(make_tick(1'b1, 15'd53, 1'b1, 15'd53, 1'b0, 23'd6400, 23'd6400));

        // Integral and derivative at full gain: both integral clamps, derivative kick
        load_gains(16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, REG_UNMAPPED_HI);
        send_tick(make_tick(1'b1, 15'd0, 1'b1, 15'd0, 1'b0, 23'd1000000, 23'd1000000));
        send_tick(make_tick(1'b1, 15'd0, 1'b1, 15'd0, 1'b0, 23'd0, 23'd0));
        send_tick(make_tick(1'b1, 15'd0, 1'b1, 15'd0, 1'b0, -23'sd1000000, -23'sd1000000));
        send_tick(make_tick(1'b0, 15'h7FFF, 1'b1, 15'h7FFF, 1'b0, 23'd0, 23'd0));
        send_tick(make_tick(1'b1, 15'd10, 1'b0, 15'd10, 1'b1, 23'd0, 23'd0));

        // All gains at maximum, extreme fields
        load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   REG_UNMAPPED_LO);
        send_tick(make_tick(1'b1, 15'h7FFF, 1'b0, 15'h7FFF, 1'b1, 23'h400000, 23'h3FFFFF));
        send_tick(make_tick(1'b1, 15'h7FFF, 1'b1, 15'h7FFF, 1'b0, 23'h3FFFFF, 23'h400000));
        send_tick(make_tick(1'b1, 15'd0, 1'b1, 15'd0, 1'b0, 23'd0, 23'd0));

        // Random ticks under a series of gain settings
        load_gains(GAIN_W'($urandom_range(0, 512)), GAIN_W'($urandom_range(0, 512)),
                   GAIN_W'($urandom_range(0, 512)), GAIN_W'($urandom_range(0, 512)),
                   GAIN_W'($urandom_range(0, 512)), GAIN_W'($urandom_range(0, 512)),
                   REG_UNMAPPED_HI);
        run_phase(PHASE_TICKS);
        load_gains(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                   REG_UNMAPPED_LO);
        run_phase(PHASE_TICKS);
        load_gains(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                   GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom),
                   REG_UNMAPPED_HI);
        run_phase(PHASE_TICKS);
        load_gains(16'd0, GAIN_W'($urandom_range(0, 2048)), 16'd0,
                   16'd0, GAIN_W'($urandom_range(0, 2048)), 16'd0, REG_UNMAPPED_LO);
        run_phase(PHASE_TICKS);
        load_gains(GAIN_W'($urandom_range(0, 1024)), GAIN_W'($urandom_range(0, 1024)),
                   GAIN_W'($urandom_range(0, 1024)), GAIN_W'($urandom_range(0, 1024)),
                   GAIN_W'($urandom_range(0, 1024)), GAIN_W'($urandom_range(0, 1024)),
                   REG_UNMAPPED_HI);
        run_phase(PHASE_TICKS);
        // back-to-back on both sides to finish
        quiet = 1'b1;
        load_gains(GAIN_W'($urandom_range(0, 512)), GAIN_W'($urandom_range(0, 512)),
                   GAIN_W'($urandom_range(0, 512)), GAIN_W'($urandom_range(0, 512)),
                   GAIN_W'($urandom_range(0, 512)), GAIN_W'($urandom_range(0, 512)),
                   REG_UNMAPPED_LO);
        run_phase(PHASE_TICKS);

        settle();
        repeat (8) @(posedge aclk);
        $display("Checked %0d results of %0d ticks (%0d with loops off), %0d gain settings.",
                 sb.checked, sb.ticks, sb.idle_ticks, settings);
        $display("Duty reached its limit %0d times; drive reversed %0d times.",
                 sb.saturated, sb.reversed);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
